// ===== rtl/vmt_pkg.sv =====
// Package for the vertex transform: shared constants and opcode enum.
// No dependencies.
package vmt_pkg;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned InDataW = 168;
  localparam int unsigned InUserW = 1;
  localparam int unsigned OutDataW = 192;
  typedef enum logic {OP_LOAD = 1'b0, OP_VERTEX = 1'b1} op_e;
  typedef enum logic [1:0] {SEL_MODEL = 2'd0, SEL_VIEW = 2'd1, SEL_PROJ = 2'd2,
                            SEL_NONE = 2'd3} sel_e;
endpackage

// ===== rtl/vertex_mvp_transform.sv =====
// Vertex transform top: pipelined model/view/projection transform and divide.
// Depends on vmt_pkg.
// Pipeline: entry register, three 3-stage matrix units, a divider setup
// register, 33 divider stages, output register.
// Throughput one vertex per cycle while the output is not stalled; a load waits
// while a vertex still has a matrix stage ahead of it. Stalls freeze the whole pipeline.
// Reset (async, active low) clears valid bits and sets all matrices to identity.
module vertex_mvp_transform #(
  parameter int unsigned FRAC_BITS = vmt_pkg::FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tuser: op
  input  logic [vmt_pkg::InUserW-1:0] s_axis_tuser,
  // tdata: matrix_sel[1:0], row_index[3:2], col_index[5:4], elem_value[37:6],
  //        pos_x[69:38], pos_y[101:70], pos_z[133:102], zero fill
  input  logic [vmt_pkg::InDataW-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tuser: w_zero
  output logic m_axis_tuser,
  // tdata: clip_x, clip_y, clip_z, ndc_x, ndc_y, ndc_z (32 bits each, low first)
  output logic [vmt_pkg::OutDataW-1:0] m_axis_tdata
);
  import vmt_pkg::*;

  localparam int unsigned MatStg = 3;   // per matrix: multiply, sum, round
  localparam int unsigned DivStg = 33;  // one quotient bit per stage
  localparam int unsigned NStg = 2 + 3 * MatStg + DivStg;

  logic adv;
  logic ld_hold;
  logic [NStg-1:0] vld_q;
  assign adv = !m_axis_tvalid || m_axis_tready;
  // matrices are read live by the product stages, so a load waits until no
  // vertex still has a product stage ahead of it
  assign ld_hold = (s_axis_tuser[0] == OP_LOAD) && (|vld_q[2*MatStg-1:0]);
  assign s_axis_tready = adv && !ld_hold;

  // ---- matrix store ----
  logic signed [31:0] mat_q [3][16];
  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  wire [1:0] sel_w = s_axis_tdata[1:0];
  wire [3:0] idx_w = {s_axis_tdata[3:2], s_axis_tdata[5:4]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < 3; m++)
        for (int i = 0; i < 16; i++)
          mat_q[m][i] <= (i % 5 == 0) ? 32'(1 << FRAC_BITS) : 32'sd0;
    end else if (acc_in && s_axis_tuser[0] == OP_LOAD && sel_w != SEL_NONE) begin
      mat_q[sel_w][idx_w] <= $signed(s_axis_tdata[37:6]);
    end
  end

  function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] s);
    logic signed [66:0] t;
    t = (67'(s) + 67'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (t > 67'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (t < -67'sh80000000) return -32'sh80000000;
    return t[31:0];
  endfunction

  // ---- matrix stages (loads are held off while a vertex would still read
  // a matrix, so each vertex sees the matrices of its transfer time) ----
  logic signed [31:0] v_q [4][4];            // vector into each matrix stage
  logic signed [63:0] p_q [3][4][4];         // products
  logic signed [65:0] s_q [3][4];            // row sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NStg-2:0], acc_in && s_axis_tuser[0] == OP_VERTEX};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_q[0][0] <= $signed(s_axis_tdata[69:38]);
      v_q[0][1] <= $signed(s_axis_tdata[101:70]);
      v_q[0][2] <= $signed(s_axis_tdata[133:102]);
      v_q[0][3] <= 32'(1 << FRAC_BITS);
      for (int m = 0; m < 3; m++) begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++)
            p_q[m][r][c] <= mat_q[m][r*4+c] * v_q[m][c];
          s_q[m][r] <= 66'(p_q[m][r][0]) + 66'(p_q[m][r][1]) + 66'(p_q[m][r][2])
                     + 66'(p_q[m][r][3]);
          v_q[m+1][r] <= rnd_sat(s_q[m][r]);
        end
      end
    end
  end

  // ---- divider: restoring, one bit per stage, 3 lanes ----
  // v_q[1..3] pipeline alignment: v_q[m+1] follows v_q[m] through p_q[m] and s_q[m].
  localparam int unsigned NW = 32 + FRAC_BITS;  // numerator width
  localparam int unsigned QW = 33;
  logic [31:0] clip_q [DivStg+1][4];
  logic [31:0] den_q [DivStg+1];
  logic [NW-1:0] rem_q [DivStg+1][3];
  logic [QW-1:0] q_q [DivStg+1][3];
  logic [2:0] ng_q [DivStg+1];

  // quotient bit (QW-1-j): subtract den << (QW-1-j) from the remainder if it fits;
  // a quotient of 2^33 or more ends as all ones and saturates later
  function automatic logic [NW+QW-1:0] divstep(input logic [NW-1:0] r,
      input logic [31:0] d, input int j, input logic [QW-1:0] q);
    logic [NW+QW-1:0] ds;
    ds = (NW+QW)'(d) << (QW - 1 - j);
    if ((NW+QW)'(r) >= ds) return {r - ds[NW-1:0], q | (QW'(1) << (QW - 1 - j))};
    return {r, q};
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) clip_q[0][k] <= v_q[3][k];
      den_q[0] <= 32'(v_q[3][3][31] ? -33'(v_q[3][3]) : 33'(v_q[3][3]));
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= (NW'(v_q[3][l][31] ? -33'(v_q[3][l]) : 33'(v_q[3][l])) << FRAC_BITS)
                     + NW'(((v_q[3][3][31] ? -33'(v_q[3][3]) : 33'(v_q[3][3]))) >> 1);
        ng_q[0][l] <= v_q[3][l][31] ^ v_q[3][3][31];
        q_q[0][l] <= '0;
      end
      for (int j = 0; j < DivStg; j++) begin
        clip_q[j+1] <= clip_q[j];
        den_q[j+1] <= den_q[j];
        ng_q[j+1] <= ng_q[j];
        for (int l = 0; l < 3; l++)
          {rem_q[j+1][l], q_q[j+1][l]} <= divstep(rem_q[j][l], den_q[j], j, q_q[j][l]);
      end
    end
  end

  logic [191:0] od_q;
  logic ow_q;
  logic ov_q;
  function automatic logic [31:0] fin(input logic [QW-1:0] q, input logic n);
    if (!n) return (q > QW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
    if (q >= QW'(33'h80000000)) return 32'h80000000;
    return -q[31:0];
  endfunction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= vld_q[NStg-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ow_q <= clip_q[DivStg][3] == 32'd0;
      for (int l = 0; l < 3; l++) begin
        od_q[32*l +: 32] <= clip_q[DivStg][l];
        od_q[96+32*l +: 32] <= (clip_q[DivStg][3] == 32'd0) ? 32'd0
                               : fin(q_q[DivStg][l], ng_q[DivStg][l]);
      end
    end
  end
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;
  assign m_axis_tuser = ow_q;

  wire unused_w = ^{s_axis_tdata[167:134]};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_wz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[191:96] == 96'd0)
    else $error("ndc not zero with w_zero");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && s_axis_tuser[0] == OP_VERTEX |-> s_axis_tready)
    else $error("vertex stalled with empty output");
endmodule

// ===== bench/vertex_mvp_transform_test.sv =====
// Self-checking bench for vertex_mvp_transform: directed and random matrix loads
// and vertex transfers, with a scoreboard that predicts clip and NDC results.
// Depends on vmt_pkg and the vertex_mvp_transform RTL.
`timescale 1ns / 1ps

module vertex_mvp_transform_test;
  import vmt_pkg::*;

  localparam int unsigned Frac = FracBitsDef;
  localparam int OneFx = 1 << Frac;
  localparam int IdleLimit = 5000;  // cycles without any transfer
  localparam int DrainCycles = 80;  // margin beyond the pipeline depth
  localparam int RandomItems = 450;

  typedef struct {
    int   clip[3];
    int   ndc[3];
    logic w_zero;
  } vertex_out_t;

  // Holds the three matrices and the expected results in flight.
  class transform_scoreboard;
    int          mat[3][16];
    vertex_out_t pending_q[$];
    int          errors;

    function new();
      for (int s = 0; s < 3; s++)
        for (int i = 0; i < 16; i++) mat[s][i] = (i % 5 == 0) ? OneFx : 0;
      errors = 0;
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
    endtask

    // one matrix stage: exact sum, round half up, saturate to 32 bits
    function void mat_stage(int sel, int v[4], output int o[4]);
      logic signed [71:0] acc;
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int c = 0; c < 4; c++)
          acc += 72'(longint'(mat[sel][r*4+c]) * longint'(v[c]));
        acc = (acc + (72'sd1 <<< (Frac - 1))) >>> Frac;
        if (acc > 72'sh7FFFFFFF) o[r] = 32'h7FFFFFFF;
        else if (acc < -72'sh80000000) o[r] = 32'h80000000;
        else o[r] = int'(acc[31:0]);
      end
    endfunction

    // perspective divide, nearest with ties away from zero, saturated
    function int ndc_divide(int c, int w);
      longint cc, ww;
      longint unsigned nm, dm, q;
      bit neg;
      cc = c;
      ww = w;
      nm = longint'(cc < 0 ? -cc : cc) << Frac;
      dm = ww < 0 ? -ww : ww;
      q = (nm + dm / 2) / dm;
      neg = (cc < 0) != (ww < 0);
      if (!neg) return (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : int'(q);
      if (q >= 64'h80000000) return 32'h80000000;
      return int'(-longint'(q));
    endfunction

    function void note_input(op_e op, logic [InDataW-1:0] d);
      int v0[4], v1[4], v2[4], v3[4];
      vertex_out_t e;
      sel_e sel;
      sel = sel_e'(d[1:0]);
      if (op == OP_LOAD) begin
        if (sel != SEL_NONE) mat[sel][{d[3:2], d[5:4]}] = int'(d[37:6]);
        return;
      end
      v0[0] = int'(d[69:38]);
      v0[1] = int'(d[101:70]);
      v0[2] = int'(d[133:102]);
      v0[3] = OneFx;
      mat_stage(SEL_MODEL, v0, v1);
      mat_stage(SEL_VIEW, v1, v2);
      mat_stage(SEL_PROJ, v2, v3);
      e.w_zero = (v3[3] == 0);
      for (int i = 0; i < 3; i++) begin
        e.clip[i] = v3[i];
        e.ndc[i] = e.w_zero ? 0 : ndc_divide(v3[i], v3[3]);
      end
      pending_q.push_back(e);
    endfunction

    task check_result(logic [OutDataW-1:0] d, logic wz);
      vertex_out_t e;
      if (pending_q.size() == 0) begin
        report("unexpected result", d[31:0], 0);
        return;
      end
      e = pending_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (d[32*i +: 32] !== e.clip[i]) report("clip", d[32*i +: 32], e.clip[i]);
        if (d[32*(i+3) +: 32] !== e.ndc[i]) report("ndc", d[32*(i+3) +: 32], e.ndc[i]);
      end
      if (wz !== e.w_zero) report("w_zero", wz, e.w_zero);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InUserW-1:0] s_axis_tuser = '0;    // op
  logic [InDataW-1:0] s_axis_tdata = '0;    // sel, row, col, elem, pos_x/y/z
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic m_axis_tuser;                        // w_zero
  logic [OutDataW-1:0] m_axis_tdata;         // clip_x/y/z, ndc_x/y/z

  transform_scoreboard sb = new();
  bit calm = 1'b0;       // no gaps on either side while set
  bit hold_go = 1'b0;    // asks the receiver for one long hold-off
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  vertex_mvp_transform u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata
  );

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // field values: small Q16.16, extremes, and fully random
  function int pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return int'($urandom_range(0, 8 * OneFx)) - 4 * OneFx;
    if (r < 75) return $urandom;
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return OneFx;
    endcase
  endfunction

  function logic [InDataW-1:0] pack_item(logic [1:0] sel, logic [1:0] row,
                                         logic [1:0] col, int elem,
                                         int px, int py, int pz);
    logic [InDataW-1:0] d;
    d = '0;
    d[1:0] = sel;
    d[3:2] = row;
    d[5:4] = col;
    d[37:6] = elem;
    d[69:38] = px;
    d[101:70] = py;
    d[133:102] = pz;
    return d;
  endfunction

  // one transfer on the input side; entered and left at a falling edge
  task send_item(op_e op, logic [InDataW-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, d);
    @(negedge clk_i);
  endtask

  task send_load(sel_e sel, int row, int col, int val);
    send_item(OP_LOAD, pack_item(sel, 2'(row), 2'(col), val, $urandom, $urandom, $urandom));
  endtask

  task send_vertex(int px, int py, int pz);
    send_item(OP_VERTEX, pack_item(2'($urandom), 2'($urandom), 2'($urandom), $urandom,
                                   px, py, pz));
  endtask

  // receiver: random stalls, plus the one long hold-off on request
  initial begin
    int stall, hold;
    stall = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // result monitor
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);

  // watchdog: any transfer on either side resets the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: identity path at the field extremes
    send_vertex(0, 0, 0);
    send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
    // unused selector must leave every matrix alone
    send_load(SEL_NONE, 3, 3, 32'h7FFFFFFF);
    send_load(SEL_NONE, 0, 0, 32'h80000000);
    send_vertex(OneFx, -OneFx, 3 * OneFx);
    // clip w of zero forces NDC to zero and raises the flag
    send_load(SEL_PROJ, 3, 3, 0);
    send_vertex(OneFx, 2 * OneFx, -OneFx);
    // w of 2.0: odd LSBs land exactly on rounding ties
    send_load(SEL_PROJ, 3, 3, 2 * OneFx);
    send_vertex(1, -1, 3);
    // tiny w drives the divide into saturation
    send_load(SEL_PROJ, 3, 3, 1);
    send_vertex(5 * OneFx, -5 * OneFx, 0);
    // huge model terms saturate the first stage
    send_load(SEL_PROJ, 3, 3, OneFx);
    send_load(SEL_MODEL, 0, 0, 32'h7FFFFFFF);
    send_load(SEL_MODEL, 1, 3, 32'h80000000);
    send_vertex(32'h7FFFFFFF, 0, 0);
    send_vertex(32'h80000000, 0, 0);
    send_load(SEL_MODEL, 0, 0, OneFx);
    send_load(SEL_MODEL, 1, 3, 0);
    send_load(SEL_VIEW, 2, 1, -OneFx / 2);
    send_vertex(OneFx, OneFx, OneFx);

    // random: three of four items are vertices, matrices churn slowly
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 100) hold_go = 1'b1;
      calm = (n >= 200 && n < 260);
      if ($urandom_range(0, 3) == 0)
        send_load(sel_e'($urandom_range(0, 9) == 0 ? SEL_NONE : $urandom_range(0, 2)),
                  $urandom_range(0, 3), $urandom_range(0, 3), pick_value());
      else
        send_vertex(pick_value(), pick_value(), pick_value());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/vmt_pkg.sv
rtl/vertex_mvp_transform.sv
bench/vertex_mvp_transform_test.sv
